>>> src/hpq_pkg.sv
// hpq_pkg: shared word types and status codes of the heap priority queue
// no dependencies; used by hpq_ctrl and binary_min_heap_priority_queue
`default_nettype none

package hpq_pkg;

  localparam int VALUE_W    = 16;
  localparam int PRIORITY_W = 16;
  localparam int COUNT_W    = 7;

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_EXTRACTED  = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef struct packed {
    req_e                  req_type;
    logic [VALUE_W-1:0]    item_value;
    logic [PRIORITY_W-1:0] item_priority;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    status_e            status;
    logic [COUNT_W-1:0] entry_count;
  } out_word_t;

endpackage

`default_nettype wire

>>> src/hpq_mem.sv
// hpq_mem: heap entry storage, one write port and two registered read ports
// no package dependency
`default_nettype none

module hpq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> src/hpq_ctrl.sv
// hpq_ctrl: sift sequencer, entry count and result word of the heap queue
// depends on hpq_pkg; drives the ports of hpq_mem
`default_nettype none

module hpq_ctrl #(
  parameter int CAPACITY      = 64,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 16,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int EW = VALUE_BITS + PRIORITY_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire hpq_pkg::in_word_t in_word_i,
  output logic                   in_stall_o,
  output logic                   res_valid_o,
  output hpq_pkg::out_word_t     res_word_o,
  input  wire logic              res_ready_i,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output logic [EW-1:0]          mem_wdata_o,
  output logic [AW-1:0]          mem_raddr_a_o,
  output logic [AW-1:0]          mem_raddr_b_o,
  input  wire logic [EW-1:0]     mem_rdata_a_i,
  input  wire logic [EW-1:0]     mem_rdata_b_i
);

  localparam int XW      = AW + 2;
  localparam int OutVW   = hpq_pkg::VALUE_W;
  localparam int OutCW   = hpq_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_RD,
    S_EX_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [CW-1:0]            count_q;
  logic [AW-1:0]            pos_q;
  logic [VALUE_BITS-1:0]    item_val_q;
  logic [PRIORITY_BITS-1:0] item_pri_q;
  logic [VALUE_BITS-1:0]    res_value_q;
  hpq_pkg::status_e         status_q;
  logic                     has_right_q;

  logic [AW-1:0]            parent;
  logic [XW-1:0]            left_x;
  logic [XW-1:0]            right_x;
  logic [XW-1:0]            count_x;
  logic                     left_ok;
  logic                     right_ok;
  logic [PRIORITY_BITS-1:0] a_pri;
  logic [PRIORITY_BITS-1:0] b_pri;
  logic [PRIORITY_BITS-1:0] best_pri;
  logic                     up_swap;
  logic                     take_left;
  logic                     take_right;
  logic [EW-1:0]            item_entry;

  // tree links of the current node
  assign parent   = (pos_q - AW'(1)) >> 1;
  assign left_x   = {1'b0, pos_q, 1'b1};
  assign right_x  = left_x + XW'(1);
  assign count_x  = XW'(count_q);
  assign left_ok  = left_x < count_x;
  assign right_ok = right_x < count_x;

  assign a_pri      = mem_rdata_a_i[PRIORITY_BITS-1:0];
  assign b_pri      = mem_rdata_b_i[PRIORITY_BITS-1:0];
  assign item_entry = {item_val_q, item_pri_q};

  // strict compares keep equal priorities in place, left child wins a tie
  assign up_swap    = a_pri > item_pri_q;
  assign take_left  = a_pri < item_pri_q;
  assign best_pri   = take_left ? a_pri : item_pri_q;
  assign take_right = has_right_q && (b_pri < best_pri);

  always_comb begin
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = item_entry;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;
    case (state_q)
      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
        end else begin
          mem_raddr_a_o = parent;
        end
      end
      S_UP_CMP: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = up_swap ? mem_rdata_a_i : item_entry;
      end
      S_EX_RD: begin
        // root and the entry that was last before the count dropped
        mem_raddr_b_o = AW'(count_q);
      end
      S_DN_RD: begin
        if (!left_ok) begin
          mem_we_o = 1'b1;
        end else begin
          mem_raddr_a_o = left_x[AW-1:0];
          mem_raddr_b_o = right_ok ? right_x[AW-1:0] : '0;
        end
      end
      S_DN_CMP: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = take_right ? mem_rdata_b_i :
                      take_left  ? mem_rdata_a_i : item_entry;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      item_val_q  <= '0;
      item_pri_q  <= '0;
      res_value_q <= '0;
      status_q    <= hpq_pkg::ST_INSERTED;
      has_right_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_val_q  <= VALUE_BITS'(in_word_i.item_value);
            item_pri_q  <= PRIORITY_BITS'(in_word_i.item_priority);
            res_value_q <= '0;
            if (in_word_i.req_type == hpq_pkg::REQ_INSERT) begin
              if (count_q == CW'(CAPACITY)) begin
                status_q <= hpq_pkg::ST_FULL;
                state_q  <= S_DONE;
              end else begin
                pos_q    <= AW'(count_q);
                count_q  <= count_q + CW'(1);
                status_q <= hpq_pkg::ST_INSERTED;
                state_q  <= S_UP_RD;
              end
            end else begin
              if (count_q == '0) begin
                status_q <= hpq_pkg::ST_EMPTY;
                state_q  <= S_DONE;
              end else begin
                count_q  <= count_q - CW'(1);
                status_q <= hpq_pkg::ST_EXTRACTED;
                state_q  <= S_EX_RD;
              end
            end
          end
        end
        S_UP_RD: begin
          state_q <= (pos_q == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_swap) begin
            pos_q   <= parent;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_EX_RD: begin
          state_q <= S_EX_LOAD;
        end
        S_EX_LOAD: begin
          res_value_q <= mem_rdata_a_i[EW-1:PRIORITY_BITS];
          item_val_q  <= mem_rdata_b_i[EW-1:PRIORITY_BITS];
          item_pri_q  <= b_pri;
          pos_q       <= '0;
          state_q     <= S_DN_RD;
        end
        S_DN_RD: begin
          if (!left_ok) begin
            state_q <= S_DONE;
          end else begin
            has_right_q <= right_ok;
            state_q     <= S_DN_CMP;
          end
        end
        S_DN_CMP: begin
          if (take_right) begin
            pos_q   <= right_x[AW-1:0];
            state_q <= S_DN_RD;
          end else if (take_left) begin
            pos_q   <= left_x[AW-1:0];
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_word_o.out_value   = OutVW'(res_value_q);
    res_word_o.status      = status_q;
    res_word_o.entry_count = OutCW'(count_q);
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_sift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_UP_RD || state_q == S_UP_CMP ||
                  state_q == S_DN_RD || state_q == S_DN_CMP))
    else $error("memory write outside a sift");

  a_dn_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DN_CMP) |-> (CW'(pos_q) < count_q))
    else $error("sift-down node beyond the filled range");

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_CMP) |-> (pos_q != '0))
    else $error("sift-up compare at the root");

  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE))
    else $error("accepted word dropped without a result");

endmodule

`default_nettype wire

>>> src/binary_min_heap_priority_queue.sv
// binary_min_heap_priority_queue: top level of the fixed-capacity heap queue
// depends on hpq_pkg, hpq_mem and hpq_ctrl
// insert: the entry climbs from the new last slot, a read state then a compare-and-write
//   state per level, until its parent is not larger or it reaches the root; extract reads
//   the root and the last entry, loads them, then sifts down the same way; one word in
//   flight, the next taken only after the result word has gone to the output register
// reset: entry count cleared and output word invalid; entry memory is not cleared
`default_nettype none

module binary_min_heap_priority_queue #(
  parameter int CAPACITY      = 64,
  parameter int VALUE_BITS    = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request channel
  input  wire logic               in_valid_i,
  input  wire hpq_pkg::in_word_t  in_word_i,
  output logic                    in_stall_o,
  // result channel
  output logic                    out_valid_o,
  output hpq_pkg::out_word_t      out_word_o,
  input  wire logic               out_stall_i
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = VALUE_BITS + PRIORITY_BITS;

  // memory port between sequencer and storage
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [EW-1:0] mem_rdata_a;
  logic [EW-1:0] mem_rdata_b;

  // result handoff into the output register
  logic               res_valid;
  logic               res_ready;
  hpq_pkg::out_word_t res_word;

  logic               out_valid_q;
  hpq_pkg::out_word_t out_word_q;

  // entries are {value, priority}; the sifted entry lives in a register and
  // is written once at its final slot, parents or children move into the hole
  hpq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // read and write of a level fall in different cycles, so no forwarding needed
  hpq_ctrl #(
    .CAPACITY      (CAPACITY),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_word_i     (in_word_i),
    .in_stall_o    (in_stall_o),
    .res_valid_o   (res_valid),
    .res_word_o    (res_word),
    .res_ready_i   (res_ready),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload holds while stalled, since res_ready is low then
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
